// ===== hw/rtl/ebr_pkg.sv =====
package ebr_pkg;

    // Default sizes for the top-level parameters.
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int VECTOR_BITS_DEF = 16;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int MAX_STAGES      = 24;

    // Angles are degrees times 128.
    localparam int HALF_TURN    = 23040;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;

    // Width of a reduced angle; it holds values up to twice a full turn.
    localparam int RES_BITS = 18;

    // Degrees times 128 to degrees times 2^24.
    localparam int CORDIC_SHIFT = 17;

    // CORDIC datapath widths: x and y are Q30, z is degrees times 2^24.
    localparam int XY_BITS   = 33;
    localparam int Z_BITS    = 34;
    localparam int INV_GAIN  = 652032874;

    // Rounded sine and cosine are Q15.
    localparam int TRIG_FRAC = 15;
    localparam int TRIG_BITS = 18;
    localparam int PAIR_BITS = 32;

    // Register stages in front of and behind the CORDIC chain.
    localparam int WRAP_LAT = 3;
    localparam int MAT_LAT  = 6;

    // Arctangent of 2^-i in degrees times 2^24.
    localparam logic signed [Z_BITS-1:0] ATAN_TAB [MAX_STAGES] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018522,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

    // One CORDIC lane: rotation state plus the cosine sign flag.
    typedef struct packed {
        logic                      neg;
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic signed [Z_BITS-1:0]  z;
    } ebr_lane_t;

endpackage

// ===== hw/rtl/ebr_wrap.sv =====
module ebr_wrap #(
    parameter int ANGLE_BITS = ebr_pkg::ANGLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output ebr_pkg::ebr_lane_t           lane
);
    import ebr_pkg::*;

    localparam int     SH     = ANGLE_BITS + 17;
    localparam longint RECIP  = ((64'sd1 <<< SH) + FULL_TURN - 1) / FULL_TURN;
    localparam int     RW     = $clog2(RECIP) + 1;
    localparam int     PWA    = ANGLE_BITS + RW;

    localparam logic signed [PWA-1:0]      RECIP_C = PWA'(RECIP);
    localparam logic signed [PWA-1:0]      FULL_C  = PWA'(FULL_TURN);
    localparam logic signed [RES_BITS-1:0] R_FULL  = RES_BITS'(FULL_TURN);
    localparam logic signed [RES_BITS-1:0] R_HALF  = RES_BITS'(HALF_TURN);
    localparam logic signed [RES_BITS-1:0] R_QUART = RES_BITS'(QUARTER_TURN);

    logic signed [PWA-1:0]        prod_reg, prod_next;
    logic signed [ANGLE_BITS-1:0] ang_reg;
    logic signed [PWA-1:0]        quot;
    logic signed [PWA-1:0]        rem_wide;
    logic signed [RES_BITS-1:0]   rem_reg, rem_next;
    logic signed [RES_BITS-1:0]   rem1, rem2, folded;
    ebr_lane_t                    lane_reg, lane_next;

    // Quotient estimate by a reciprocal multiply; it is low by at most one.
    always_comb begin
        prod_next = PWA'(angle) * RECIP_C;
    end

    // Remainder of the estimate lies in zero up to twice a full turn.
    always_comb begin
        quot     = prod_reg >>> SH;
        rem_wide = PWA'(ang_reg) - quot * FULL_C;
        rem_next = rem_wide[RES_BITS-1:0];
    end

    // Bring the remainder into the half-open half turn, then fold to +-90 degrees.
    always_comb begin
        rem1 = (rem_reg >= R_FULL) ? rem_reg - R_FULL : rem_reg;
        rem2 = (rem1 > R_HALF) ? rem1 - R_FULL : rem1;
        lane_next.neg = 1'b0;
        folded        = rem2;
        if (rem2 > R_QUART) begin
            folded        = R_HALF - rem2;
            lane_next.neg = 1'b1;
        end else if (rem2 < -R_QUART) begin
            folded        = -R_HALF - rem2;
            lane_next.neg = 1'b1;
        end
        lane_next.x = XY_BITS'(INV_GAIN);
        lane_next.y = '0;
        lane_next.z = Z_BITS'(folded) <<< CORDIC_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            ang_reg  <= angle;
            rem_reg  <= rem_next;
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

// ===== hw/rtl/ebr_cell.sv =====
module ebr_cell #(
    parameter int STAGE = 0
) (
    input  logic                     aclk,
    input  logic                     en,
    input  ebr_pkg::ebr_lane_t [2:0] lane_in,
    output ebr_pkg::ebr_lane_t [2:0] lane_out
);
    import ebr_pkg::*;

    ebr_lane_t [2:0]           lane_reg, lane_next;
    logic signed [XY_BITS-1:0] dx [3];
    logic signed [XY_BITS-1:0] dy [3];

    // One CORDIC micro-rotation on each of the three angle lanes.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dx[i] = lane_in[i].y >>> STAGE;
            dy[i] = lane_in[i].x >>> STAGE;
            lane_next[i].neg = lane_in[i].neg;
            if (!lane_in[i].z[Z_BITS-1]) begin
                lane_next[i].x = lane_in[i].x - dx[i];
                lane_next[i].y = lane_in[i].y + dy[i];
                lane_next[i].z = lane_in[i].z - ATAN_TAB[STAGE];
            end else begin
                lane_next[i].x = lane_in[i].x + dx[i];
                lane_next[i].y = lane_in[i].y - dy[i];
                lane_next[i].z = lane_in[i].z + ATAN_TAB[STAGE];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== hw/rtl/ebr_matrix.sv =====
module ebr_matrix #(
    parameter int VECTOR_BITS = ebr_pkg::VECTOR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  ebr_pkg::ebr_lane_t [2:0]      lanes,
    input  logic signed [VECTOR_BITS:0]   xb,
    input  logic signed [VECTOR_BITS:0]   yb,
    input  logic signed [VECTOR_BITS:0]   zb,
    output logic signed [VECTOR_BITS:0]   world_x,
    output logic signed [VECTOR_BITS:0]   world_y,
    output logic signed [VECTOR_BITS:0]   world_z
);
    import ebr_pkg::*;

    localparam int VW  = VECTOR_BITS + 1;
    localparam int TW  = TRIG_BITS;
    localparam int PW  = PAIR_BITS;
    localparam int TPW = PAIR_BITS + TRIG_BITS;
    localparam int PRW = TW + VW;
    localparam int SW  = PRW + 2;
    localparam logic signed [SW-1:0] LIM_HI = SW'((longint'(1) <<< VECTOR_BITS) - 1);
    localparam logic signed [SW-1:0] LIM_LO = -SW'(longint'(1) <<< VECTOR_BITS);

    // Q30 to Q15, half up.
    function automatic logic signed [TW-1:0] trig_round(input logic signed [XY_BITS-1:0] v);
        logic signed [XY_BITS-1:0] t;
        t = (v + XY_BITS'(1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        return t[TW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] mul_pair(input logic signed [TW-1:0] a,
                                                       input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b;
        return p[PW-1:0];
    endfunction

    function automatic logic signed [TPW-1:0] mul_trip(input logic signed [PW-1:0] a,
                                                        input logic signed [TW-1:0] b);
        logic signed [TPW-1:0] p;
        p = a * b;
        return p;
    endfunction

    // Entry from a Q45 triple plus or minus a Q30 pair, rounded to Q15.
    function automatic logic signed [TW-1:0] ent3(input logic signed [TPW-1:0] trip,
                                                   input logic signed [PW-1:0]  pair,
                                                   input logic                  sub);
        logic signed [TPW:0] t;
        logic signed [TPW:0] p;
        p = (TPW+1)'(pair) <<< TRIG_FRAC;
        t = (TPW+1)'(trip) + (sub ? -p : p);
        t = (t + ((TPW+1)'(1) <<< (2*TRIG_FRAC - 1))) >>> (2*TRIG_FRAC);
        return t[TW-1:0];
    endfunction

    // Entry from a Q30 pair, rounded to Q15.
    function automatic logic signed [TW-1:0] ent2(input logic signed [PW-1:0] pair);
        logic signed [PW-1:0] t;
        t = (pair + PW'(1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        return t[TW-1:0];
    endfunction

    function automatic logic signed [PRW-1:0] mul_vec(input logic signed [TW-1:0] m,
                                                       input logic signed [VW-1:0] v);
        logic signed [PRW-1:0] p;
        p = m * v;
        return p;
    endfunction

    function automatic logic signed [VW-1:0] finish(input logic signed [PRW-1:0] a,
                                                     input logic signed [PRW-1:0] b,
                                                     input logic signed [PRW-1:0] c);
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(b) + SW'(c);
        s = (s + SW'(1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        if (s > LIM_HI) begin
            s = LIM_HI;
        end else if (s < LIM_LO) begin
            s = LIM_LO;
        end
        return s[VW-1:0];
    endfunction

    // Index 0 is roll, 1 pitch, 2 yaw.
    logic signed [TW-1:0]  cos_reg [3];
    logic signed [TW-1:0]  sin_reg [3];
    logic signed [TW-1:0]  cos_next [3];
    logic signed [VW-1:0]  xb_reg [4];
    logic signed [VW-1:0]  yb_reg [4];
    logic signed [VW-1:0]  zb_reg [4];

    logic signed [PW-1:0]  cycp_reg, cysp_reg, sycr_reg, sysr_reg, sycp_reg;
    logic signed [PW-1:0]  sysp_reg, cycr_reg, cysr_reg, cpsr_reg, cpcr_reg;
    logic signed [TW-1:0]  sp2_reg, sr2_reg, cr2_reg;

    logic signed [TPW-1:0] cyspsr_reg, cyspcr_reg, sysppsr_reg, syspcr_reg;
    logic signed [PW-1:0]  cycp3_reg, sycr3_reg, sysr3_reg, sycp3_reg;
    logic signed [PW-1:0]  cycr3_reg, cysr3_reg, cpsr3_reg, cpcr3_reg;
    logic signed [TW-1:0]  sp3_reg;

    logic signed [TW-1:0]  m_reg [9];
    logic signed [PRW-1:0] prod_reg [9];
    logic signed [VW-1:0]  wx_reg, wy_reg, wz_reg;

    // Cosine takes the sign of the fold.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cos_next[i] = lanes[i].neg ? -trig_round(lanes[i].x) : trig_round(lanes[i].x);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Rounded sines and cosines.
            for (int i = 0; i < 3; i++) begin
                cos_reg[i] <= cos_next[i];
                sin_reg[i] <= trig_round(lanes[i].y);
            end

            // Vector delay line, aligned with the matrix entries.
            xb_reg[0] <= xb;
            yb_reg[0] <= yb;
            zb_reg[0] <= zb;
            for (int i = 1; i < 4; i++) begin
                xb_reg[i] <= xb_reg[i-1];
                yb_reg[i] <= yb_reg[i-1];
                zb_reg[i] <= zb_reg[i-1];
            end

            // Products of two trig values.
            cycp_reg <= mul_pair(cos_reg[2], cos_reg[1]);
            cysp_reg <= mul_pair(cos_reg[2], sin_reg[1]);
            sycr_reg <= mul_pair(sin_reg[2], cos_reg[0]);
            sysr_reg <= mul_pair(sin_reg[2], sin_reg[0]);
            sycp_reg <= mul_pair(sin_reg[2], cos_reg[1]);
            sysp_reg <= mul_pair(sin_reg[2], sin_reg[1]);
            cycr_reg <= mul_pair(cos_reg[2], cos_reg[0]);
            cysr_reg <= mul_pair(cos_reg[2], sin_reg[0]);
            cpsr_reg <= mul_pair(cos_reg[1], sin_reg[0]);
            cpcr_reg <= mul_pair(cos_reg[1], cos_reg[0]);
            sp2_reg  <= sin_reg[1];
            sr2_reg  <= sin_reg[0];
            cr2_reg  <= cos_reg[0];

            // Products of three trig values; the pairs ride along.
            cyspsr_reg  <= mul_trip(cysp_reg, sr2_reg);
            cyspcr_reg  <= mul_trip(cysp_reg, cr2_reg);
            sysppsr_reg <= mul_trip(sysp_reg, sr2_reg);
            syspcr_reg  <= mul_trip(sysp_reg, cr2_reg);
            cycp3_reg   <= cycp_reg;
            sycr3_reg   <= sycr_reg;
            sysr3_reg   <= sysr_reg;
            sycp3_reg   <= sycp_reg;
            cycr3_reg   <= cycr_reg;
            cysr3_reg   <= cysr_reg;
            cpsr3_reg   <= cpsr_reg;
            cpcr3_reg   <= cpcr_reg;
            sp3_reg     <= sp2_reg;

            // Rotation matrix entries in Q15.
            m_reg[0] <= ent2(cycp3_reg);
            m_reg[1] <= ent3(cyspsr_reg, sycr3_reg, 1'b1);
            m_reg[2] <= ent3(cyspcr_reg, sysr3_reg, 1'b0);
            m_reg[3] <= ent2(sycp3_reg);
            m_reg[4] <= ent3(sysppsr_reg, cycr3_reg, 1'b0);
            m_reg[5] <= ent3(syspcr_reg, cysr3_reg, 1'b1);
            m_reg[6] <= -sp3_reg;
            m_reg[7] <= ent2(cpsr3_reg);
            m_reg[8] <= ent2(cpcr3_reg);

            // Entry times component.
            for (int r = 0; r < 3; r++) begin
                prod_reg[3*r]   <= mul_vec(m_reg[3*r],   xb_reg[3]);
                prod_reg[3*r+1] <= mul_vec(m_reg[3*r+1], yb_reg[3]);
                prod_reg[3*r+2] <= mul_vec(m_reg[3*r+2], zb_reg[3]);
            end

            // Row sums, rounded and saturated.
            wx_reg <= finish(prod_reg[0], prod_reg[1], prod_reg[2]);
            wy_reg <= finish(prod_reg[3], prod_reg[4], prod_reg[5]);
            wz_reg <= finish(prod_reg[6], prod_reg[7], prod_reg[8]);
        end
    end

    assign world_x = wx_reg;
    assign world_y = wy_reg;
    assign world_z = wz_reg;

endmodule

// ===== hw/rtl/euler_body_to_inertial_rotate.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and stalls
// only while a result is held at the output and not taken.
// Reset: aresetn, synchronous and active low, clears the stage valid bits only;
// the datapath registers carry no reset.
module euler_body_to_inertial_rotate #(
    parameter int ANGLE_BITS  = ebr_pkg::ANGLE_BITS_DEF,
    parameter int VECTOR_BITS = ebr_pkg::VECTOR_BITS_DEF,
    parameter int TRIG_STAGES = ebr_pkg::TRIG_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ANGLE_BITS-1:0]  s_roll_angle,
    input  logic signed [ANGLE_BITS-1:0]  s_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0]  s_yaw_angle,
    input  logic signed [VECTOR_BITS-1:0] s_body_x,
    input  logic signed [VECTOR_BITS-1:0] s_body_y,
    input  logic signed [VECTOR_BITS-1:0] s_body_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VECTOR_BITS:0]   m_world_x,
    output logic signed [VECTOR_BITS:0]   m_world_y,
    output logic signed [VECTOR_BITS:0]   m_world_z
);
    import ebr_pkg::*;

    localparam int VW    = VECTOR_BITS + 1;
    localparam int DEPTH = WRAP_LAT + TRIG_STAGES + MAT_LAT;
    localparam int VDLY  = WRAP_LAT + TRIG_STAGES;

    logic [DEPTH-1:0]       vld_reg, vld_next;
    logic                   adv;
    ebr_lane_t [2:0]        chain [TRIG_STAGES+1];
    logic signed [VW-1:0]   xb_line_reg [VDLY];
    logic signed [VW-1:0]   yb_line_reg [VDLY];
    logic signed [VW-1:0]   zb_line_reg [VDLY];

    // The pipeline moves whenever the output register is empty or being emptied.
    assign adv     = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_comb begin
        vld_next = {vld_reg[DEPTH-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Angle reduction, one unit per angle.
    ebr_wrap #(.ANGLE_BITS(ANGLE_BITS)) u_wrap_roll (
        .aclk(aclk), .en(adv), .angle(s_roll_angle), .lane(chain[0][0])
    );
    ebr_wrap #(.ANGLE_BITS(ANGLE_BITS)) u_wrap_pitch (
        .aclk(aclk), .en(adv), .angle(s_pitch_angle), .lane(chain[0][1])
    );
    ebr_wrap #(.ANGLE_BITS(ANGLE_BITS)) u_wrap_yaw (
        .aclk(aclk), .en(adv), .angle(s_yaw_angle), .lane(chain[0][2])
    );

    // CORDIC chain, one cell per micro-rotation.
    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        ebr_cell #(.STAGE(g)) u_cell (
            .aclk(aclk), .en(adv), .lane_in(chain[g]), .lane_out(chain[g+1])
        );
    end

    // Body vector follows the angles; x is negated for the SED frame.
    always_ff @(posedge aclk) begin
        if (adv) begin
            xb_line_reg[0] <= -VW'(s_body_x);
            yb_line_reg[0] <= VW'(s_body_y);
            zb_line_reg[0] <= VW'(s_body_z);
            for (int i = 1; i < VDLY; i++) begin
                xb_line_reg[i] <= xb_line_reg[i-1];
                yb_line_reg[i] <= yb_line_reg[i-1];
                zb_line_reg[i] <= zb_line_reg[i-1];
            end
        end
    end

    ebr_matrix #(.VECTOR_BITS(VECTOR_BITS)) u_matrix (
        .aclk    (aclk),
        .en      (adv),
        .lanes   (chain[TRIG_STAGES]),
        .xb      (xb_line_reg[VDLY-1]),
        .yb      (yb_line_reg[VDLY-1]),
        .zb      (zb_line_reg[VDLY-1]),
        .world_x (m_world_x),
        .world_y (m_world_y),
        .world_z (m_world_z)
    );

    // An accepted word occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    // A result word only leaves when it is taken.
    a_leave: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result word dropped without being taken");

    // A new result comes from the stage just before the output.
    a_arrive: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vld_reg[DEPTH-2]))
        else $error("result word appeared without a source");

endmodule

// ===== sim/euler_body_to_inertial_rotate_tb.sv =====
module euler_body_to_inertial_rotate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebr_pkg::*;

    localparam int AB = ANGLE_BITS_DEF;
    localparam int VB = VECTOR_BITS_DEF;
    localparam int TS = TRIG_STAGES_DEF;
    localparam int ITEMS_PER_PHASE = 150;

    typedef logic signed [VB:0] world_t;

    typedef struct {
        world_t wx;
        world_t wy;
        world_t wz;
    } world_vec_t;

    // Rotation predictor plus the queue of words still owed by the block.
    class rotate_scoreboard;
        world_vec_t owed[$];
        int mismatches;

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        // Folded rotation-mode CORDIC, rounded to Q15.
        function void sine_cosine(longint a, output longint s, output longint c);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            bit flip;
            flip = 0;
            x = INV_GAIN;
            y = 0;
            a = a % FULL_TURN;
            if (a > HALF_TURN) a -= FULL_TURN;
            if (a <= -HALF_TURN) a += FULL_TURN;
            if (a > QUARTER_TURN) begin
                a = HALF_TURN - a;
                flip = 1;
            end else if (a < -QUARTER_TURN) begin
                a = -HALF_TURN - a;
                flip = 1;
            end
            z = a * (longint'(1) << CORDIC_SHIFT);
            for (int i = 0; i < TS && i < MAX_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= longint'(ATAN_TAB[i]);
                end else begin
                    x += dx;
                    y -= dy;
                    z += longint'(ATAN_TAB[i]);
                end
            end
            c = round_shift(x, 15);
            s = round_shift(y, 15);
            if (flip) c = -c;
        endfunction

        function world_t saturate(longint acc);
            longint v;
            longint lim;
            v = round_shift(acc, TRIG_FRAC);
            lim = longint'(1) << VB;
            if (v > lim - 1) v = lim - 1;
            if (v < -lim) v = -lim;
            return world_t'(v);
        endfunction

        // Work out the inertial vector for an accepted input word.
        function void note_input(logic signed [AB-1:0] r, logic signed [AB-1:0] p,
                                 logic signed [AB-1:0] yw, logic signed [VB-1:0] bx,
                                 logic signed [VB-1:0] by, logic signed [VB-1:0] bz);
            longint sr, cr, sp, cp, sy, cy, xb, yb, zb, one;
            longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
            world_vec_t w;
            one = longint'(1) << TRIG_FRAC;
            sine_cosine(longint'(r), sr, cr);
            sine_cosine(longint'(p), sp, cp);
            sine_cosine(longint'(yw), sy, cy);
            // The body frame is SED, so x flips sign.
            xb = -longint'(bx);
            yb = longint'(by);
            zb = longint'(bz);
            m00 = round_shift(cy * cp * one, 30);
            m01 = round_shift(cy * sp * sr - sy * cr * one, 30);
            m02 = round_shift(cy * sp * cr + sy * sr * one, 30);
            m10 = round_shift(sy * cp * one, 30);
            m11 = round_shift(sy * sp * sr + cy * cr * one, 30);
            m12 = round_shift(sy * sp * cr - cy * sr * one, 30);
            m20 = -sp;
            m21 = round_shift(cp * sr * one, 30);
            m22 = round_shift(cp * cr * one, 30);
            w.wx = saturate(m00 * xb + m01 * yb + m02 * zb);
            w.wy = saturate(m10 * xb + m11 * yb + m12 * zb);
            w.wz = saturate(m20 * xb + m21 * yb + m22 * zb);
            owed = {owed, w};
        endfunction

        // Compare a result word with the oldest expectation.
        function void check_result(world_t ax, world_t ay, world_t az);
            world_vec_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word x=%0d y=%0d z=%0d", ax, ay, az);
                return;
            end
            e = owed.pop_front();
            if (e.wx !== ax || e.wy !== ay || e.wz !== az) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                             e.wx, e.wy, e.wz, ax, ay, az);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [AB-1:0] s_roll_angle = '0;
    logic signed [AB-1:0] s_pitch_angle = '0;
    logic signed [AB-1:0] s_yaw_angle = '0;
    logic signed [VB-1:0] s_body_x = '0;
    logic signed [VB-1:0] s_body_y = '0;
    logic signed [VB-1:0] s_body_z = '0;
    logic m_valid;
    logic m_ready = 0;
    world_t m_world_x;
    world_t m_world_y;
    world_t m_world_z;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    rotate_scoreboard sb = new();

    euler_body_to_inertial_rotate dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_roll_angle(s_roll_angle), .s_pitch_angle(s_pitch_angle),
        .s_yaw_angle(s_yaw_angle), .s_body_x(s_body_x),
        .s_body_y(s_body_y), .s_body_z(s_body_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_world_x(m_world_x), .m_world_y(m_world_y), .m_world_z(m_world_z)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Result side: check each accepted word and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_world_x, m_world_y, m_world_z);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one input word, idling first at random, and wait until it is taken.
    task automatic send_word(int r, int p, int yw, int bx, int by, int bz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_roll_angle <= r[AB-1:0];
        s_pitch_angle <= p[AB-1:0];
        s_yaw_angle <= yw[AB-1:0];
        s_body_x <= bx[VB-1:0];
        s_body_y <= by[VB-1:0];
        s_body_z <= bz[VB-1:0];
        do @(posedge aclk); while (!s_ready);
        sb.note_input(s_roll_angle, s_pitch_angle, s_yaw_angle, s_body_x, s_body_y, s_body_z);
    endtask

    function automatic int rand_angle();
        // Mostly the nominal range; sometimes any 16-bit pattern to exercise wrapping.
        if ($urandom_range(9) < 7)
            return $urandom_range(2 * HALF_TURN) - HALF_TURN;
        return int'($urandom());
    endfunction

    initial begin
        int phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: zero and axis angles, wrap edges, vector extremes, saturation.
        send_word(0, 0, 0, 256, 512, -768);
        send_word(QUARTER_TURN, 0, 0, 1000, 2000, 3000);
        send_word(0, QUARTER_TURN, 0, 1000, 2000, 3000);
        send_word(0, 0, QUARTER_TURN, 1000, 2000, 3000);
        send_word(-QUARTER_TURN, -QUARTER_TURN, -QUARTER_TURN, 1000, -2000, 3000);
        send_word(HALF_TURN, HALF_TURN, HALF_TURN, 4096, 4096, 4096);
        send_word(-HALF_TURN, -HALF_TURN, -HALF_TURN, 4096, 4096, 4096);
        send_word(HALF_TURN + 1, -HALF_TURN - 1, QUARTER_TURN + 1, 100, 200, 300);
        send_word(32767, -32768, 32767, 5000, -5000, 5000);
        send_word(-32768, 32767, -32768, -5000, 5000, -5000);
        send_word(0, 0, 0, -32768, 0, 0);
        send_word(0, 0, 0, 32767, 32767, 32767);
        send_word(0, 0, 0, -32768, -32768, -32768);
        send_word(5760, 5760, 5760, -32768, 32767, 32767);
        send_word(-5760, 5760, -5760, 32767, -32768, -32768);
        send_word(5760, -5760, 5760, -32768, -32768, 32767);
        send_word(QUARTER_TURN, QUARTER_TURN, QUARTER_TURN, -32768, -32768, -32768);
        send_word(1, -1, 1, 1, -1, 1);
        send_word(11519, 11521, -11521, 12345, -23456, 31000);
        send_word(FULL_TURN - 1, -FULL_TURN + 1, 0, 0, 0, 0);

        // Random words across the idling phases, each phase run twice.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_word(rand_angle(), rand_angle(), rand_angle(),
                          int'($urandom()), int'($urandom()), int'($urandom()));
        end
        s_valid <= 0;
        recv_stall_pct = 0;

        // Drain the pipeline, then allow its latency once more.
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (9 + TS + 10) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4ms;
        $display("tb: failure");
        $finish;
    end
endmodule
